// ----- rtl/tip_pkg.sv -----
// shared types, constants and character helpers for the text-to-integer parser
`timescale 1ns / 1ps
`default_nettype none

package tip_pkg;

  localparam int unsigned CHAR_W          = 8;
  localparam int unsigned RADIX_W         = 6;
  localparam int unsigned DIGIT_W         = 6;
  localparam int unsigned ERR_W           = 2;
  localparam int unsigned CFG_IDX_W       = 1;
  localparam int unsigned CFG_DATA_W      = RADIX_W;
  localparam int unsigned DEF_VALUE_WIDTH = 32;
  localparam int unsigned DEF_MAX_LEN     = 1024;
  localparam int unsigned QUEUE_DEPTH     = 2;

  localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;
  localparam logic [RADIX_W-1:0] RADIX_ONE   = 6'd1;
  localparam logic [RADIX_W-1:0] RADIX_MAX   = 6'd36;
  localparam logic [RADIX_W-1:0] RADIX_AUTO  = 6'd0;
  localparam logic [RADIX_W-1:0] BASE_MIN    = 6'd2;
  localparam logic [RADIX_W-1:0] BASE_OCT    = 6'd8;
  localparam logic [RADIX_W-1:0] BASE_DEC    = 6'd10;
  localparam logic [RADIX_W-1:0] BASE_HEX    = 6'd16;

  localparam logic [DIGIT_W-1:0] NO_DIGIT  = 6'd36;
  localparam logic [DIGIT_W-1:0] HEX_LIMIT = 6'd16;

  localparam logic [CHAR_W-1:0] CH_0      = 8'h30;
  localparam logic [CHAR_W-1:0] CH_9      = 8'h39;
  localparam logic [CHAR_W-1:0] CH_UA     = 8'h41;
  localparam logic [CHAR_W-1:0] CH_UZ     = 8'h5a;
  localparam logic [CHAR_W-1:0] CH_LA     = 8'h61;
  localparam logic [CHAR_W-1:0] CH_LZ     = 8'h7a;
  localparam logic [CHAR_W-1:0] CH_UA_OFS = CH_UA - 8'd10;
  localparam logic [CHAR_W-1:0] CH_LA_OFS = CH_LA - 8'd10;
  localparam logic [CHAR_W-1:0] CH_SPACE  = 8'h20;
  localparam logic [CHAR_W-1:0] CH_TAB    = 8'h09;
  localparam logic [CHAR_W-1:0] CH_CR     = 8'h0d;
  localparam logic [CHAR_W-1:0] CH_PLUS   = 8'h2b;
  localparam logic [CHAR_W-1:0] CH_MINUS  = 8'h2d;
  localparam logic [CHAR_W-1:0] CH_UX     = 8'h58;
  localparam logic [CHAR_W-1:0] CH_LX     = 8'h78;

  typedef enum logic [ERR_W-1:0] {
    ERR_OK    = 2'd0,
    ERR_BASE  = 2'd1,
    ERR_RANGE = 2'd2
  } err_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RADIX  = 1'b0,
    CFG_SIGNED = 1'b1
  } cfg_idx_e;

  // classified character as it travels from front to back
  typedef struct packed {
    logic               first;
    logic               is_space;
    logic               is_sign;
    logic               is_minus;
    logic               is_zero;
    logic               is_x;
    logic [DIGIT_W-1:0] digit;
  } token_t;

  function automatic logic [DIGIT_W-1:0] digit_of(input logic [CHAR_W-1:0] c);
    logic [DIGIT_W-1:0] d;
    d = NO_DIGIT;
    if (c >= CH_0 && c <= CH_9) begin
      d = DIGIT_W'(c - CH_0);
    end else if (c >= CH_UA && c <= CH_UZ) begin
      d = DIGIT_W'(c - CH_UA_OFS);
    end else if (c >= CH_LA && c <= CH_LZ) begin
      d = DIGIT_W'(c - CH_LA_OFS);
    end
    return d;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/tip_in_if.sv -----
// character channel into the parser
`timescale 1ns / 1ps
`default_nettype none

interface tip_in_if;
  logic                       valid;
  logic                       ready;
  logic [tip_pkg::CHAR_W-1:0] char_code;
  logic                       first_char;

  modport source (output valid, output char_code, output first_char, input ready);
  modport sink   (input valid, input char_code, input first_char, output ready);
endinterface

`default_nettype wire

// ----- rtl/tip_out_if.sv -----
// result channel out of the parser
`timescale 1ns / 1ps
`default_nettype none

interface tip_out_if #(
  parameter int unsigned VALUE_WIDTH = tip_pkg::DEF_VALUE_WIDTH,
  parameter int unsigned CNT_W       = $clog2(tip_pkg::DEF_MAX_LEN + 1)
);
  logic                      valid;
  logic                      ready;
  logic [VALUE_WIDTH-1:0]    value_bits;
  logic [CNT_W-1:0]          chars_used;
  logic [tip_pkg::ERR_W-1:0] error_code;

  modport source (output valid, output value_bits, output chars_used, output error_code,
                  input ready);
  modport sink   (input valid, input value_bits, input chars_used, input error_code,
                  output ready);
endinterface

`default_nettype wire

// ----- rtl/text_to_integer_parser.sv -----
// Streaming text-to-integer parser, top level.
// Characters arrive on str_i one word per cycle while str_i.ready is high;
// first_char marks the start of a new number and drops any number still in
// progress without a result. Leading whitespace, an optional sign and a 0x
// or octal prefix are handled. Radix and signed_mode are to be set on the
// cfg write port only while the block is idle, which the block itself does
// not enforce (radix 0 detects the base). One result word leaves on res_o
// at the first character that ends the number, or right away for an invalid
// radix: value, consumed count, error. Throughput is one character per cycle
// while res_o is not stalled, set by the single multiply-add by the base in
// the back end. A character that ends a number passes through the queue and
// then the result register before its result shows on res_o.
// While res_o is stalled the back end holds, the two-entry queue fills and
// str_i.ready drops only once the queue is full.
// Reset clears the queue and the result slot and puts the parser idle, with
// radix 10 and signed mode on; characters without first_char are then ignored.
`timescale 1ns / 1ps
`default_nettype none

module text_to_integer_parser #(
  parameter int unsigned VALUE_WIDTH = tip_pkg::DEF_VALUE_WIDTH,
  parameter int unsigned MAX_LEN     = tip_pkg::DEF_MAX_LEN
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [tip_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [tip_pkg::CFG_DATA_W-1:0] cfg_data_i,
  tip_in_if.sink                         str_i,
  tip_out_if.source                      res_o
);

  logic            push_valid, push_ready;
  tip_pkg::token_t push_data;
  logic            tok_valid, tok_ready;
  tip_pkg::token_t tok;

  tip_front u_front (
    .str_i        (str_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_data_o  (push_data)
  );

  tip_queue #(
    .DEPTH (tip_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  (push_data),
    .pop_valid_o  (tok_valid),
    .pop_ready_i  (tok_ready),
    .pop_data_o   (tok)
  );

  tip_back #(
    .VALUE_WIDTH (VALUE_WIDTH),
    .MAX_LEN     (MAX_LEN)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .tok_valid_i (tok_valid),
    .tok_ready_o (tok_ready),
    .tok_i       (tok),
    .res_o       (res_o)
  );

endmodule

`default_nettype wire

// ----- rtl/tip_front.sv -----
// front end: takes characters and classifies them into tokens
`timescale 1ns / 1ps
`default_nettype none

module tip_front (
  tip_in_if.sink            str_i,
  output logic              push_valid_o,
  input  logic              push_ready_i,
  output tip_pkg::token_t   push_data_o
);

  logic [tip_pkg::CHAR_W-1:0] c;

  assign c = str_i.char_code;

  assign str_i.ready  = push_ready_i;
  assign push_valid_o = str_i.valid;

  always_comb begin
    push_data_o.first    = str_i.first_char;
    push_data_o.is_space = (c == tip_pkg::CH_SPACE) ||
                           (c inside {[tip_pkg::CH_TAB:tip_pkg::CH_CR]});
    push_data_o.is_sign  = (c == tip_pkg::CH_PLUS) || (c == tip_pkg::CH_MINUS);
    push_data_o.is_minus = (c == tip_pkg::CH_MINUS);
    push_data_o.is_zero  = (c == tip_pkg::CH_0);
    push_data_o.is_x     = (c == tip_pkg::CH_UX) || (c == tip_pkg::CH_LX);
    push_data_o.digit    = tip_pkg::digit_of(c);
  end

endmodule

`default_nettype wire

// ----- rtl/tip_queue.sv -----
// short token queue between front and back
`timescale 1ns / 1ps
`default_nettype none

module tip_queue #(
  parameter int unsigned DEPTH = tip_pkg::QUEUE_DEPTH
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_valid_i,
  output logic            push_ready_o,
  input  tip_pkg::token_t push_data_i,
  output logic            pop_valid_o,
  input  logic            pop_ready_i,
  output tip_pkg::token_t pop_data_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned FILL_W = $clog2(DEPTH + 1);

  tip_pkg::token_t   mem_q [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0]  rd_ptr_q, rd_ptr_d;
  logic [FILL_W-1:0] fill_q, fill_d;
  logic              push, pop;

  assign push_ready_o = (fill_q != FILL_W'(DEPTH));
  assign pop_valid_o  = (fill_q != '0);
  assign pop_data_o   = mem_q[rd_ptr_q];

  assign push = push_valid_i && push_ready_o;
  assign pop  = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    fill_d   = fill_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      fill_d = fill_q + 1'b1;
    end else if (pop && !push) begin
      fill_d = fill_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/tip_back.sv -----
// back end: number state machine, digit accumulate, saturation and result register
`timescale 1ns / 1ps
`default_nettype none

module tip_back #(
  parameter int unsigned VALUE_WIDTH = tip_pkg::DEF_VALUE_WIDTH,
  parameter int unsigned MAX_LEN     = tip_pkg::DEF_MAX_LEN
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [tip_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [tip_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                           tok_valid_i,
  output logic                           tok_ready_o,
  input  tip_pkg::token_t                tok_i,
  tip_out_if.source                      res_o
);

  localparam int unsigned CNT_W  = $clog2(MAX_LEN + 1);
  localparam int unsigned PROD_W = VALUE_WIDTH + tip_pkg::RADIX_W;
  localparam logic [VALUE_WIDTH-1:0] SMAX = {1'b0, {(VALUE_WIDTH - 1){1'b1}}};
  localparam logic [VALUE_WIDTH-1:0] SMIN = {1'b1, {(VALUE_WIDTH - 1){1'b0}}};

  typedef enum logic [5:0] {
    PH_IDLE   = 6'b000001,
    PH_SPACE  = 6'b000010,
    PH_SIGNED = 6'b000100,
    PH_ZERO   = 6'b001000,
    PH_ZEROX  = 6'b010000,
    PH_DIGITS = 6'b100000
  } phase_e;

  logic [tip_pkg::RADIX_W-1:0] radix_q;
  logic                        signed_q;

  phase_e                      phase_q, phase_d;
  logic [VALUE_WIDTH-1:0]      acc_q, acc_d;
  logic                        neg_q, neg_d;
  logic                        ovf_q, ovf_d;
  logic                        seen_q, seen_d;
  logic [tip_pkg::RADIX_W-1:0] base_q, base_d;
  logic [CNT_W-1:0]            cnt_q, cnt_d;

  logic                        try_take, take_ok, fin, base_err, done;
  logic [PROD_W-1:0]           prod;
  logic                        pop, emit;

  logic [VALUE_WIDTH-1:0]      fin_value;
  tip_pkg::err_e               fin_err;

  logic                        res_valid_q;
  logic [VALUE_WIDTH-1:0]      res_value_q;
  logic [CNT_W-1:0]            res_cnt_q;
  tip_pkg::err_e               res_err_q;

  function automatic logic [CNT_W-1:0] bump(input logic [CNT_W-1:0] n);
    return (n < CNT_W'(MAX_LEN)) ? n + 1'b1 : n;
  endfunction

  // config registers; the user must write them only while idle, the block does not enforce it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radix_q  <= tip_pkg::RADIX_RESET;
      signed_q <= 1'b1;
    end else if (cfg_we_i) begin
      case (tip_pkg::cfg_idx_e'(cfg_idx_i))
        tip_pkg::CFG_RADIX:  radix_q  <= cfg_data_i[tip_pkg::RADIX_W-1:0];
        tip_pkg::CFG_SIGNED: signed_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // pop a token whenever the result slot is free or being drained
  assign tok_ready_o = !res_valid_q || res_o.ready;
  assign pop         = tok_valid_i && tok_ready_o;

  always_comb begin
    phase_d  = phase_q;
    acc_d    = acc_q;
    neg_d    = neg_q;
    ovf_d    = ovf_q;
    seen_d   = seen_q;
    base_d   = base_q;
    cnt_d    = cnt_q;
    try_take = 1'b0;
    take_ok  = 1'b0;
    fin      = 1'b0;
    base_err = 1'b0;
    done     = 1'b0;
    prod     = '0;

    if (tok_i.first) begin
      phase_d = PH_SPACE;
      acc_d   = '0;
      neg_d   = 1'b0;
      ovf_d   = 1'b0;
      seen_d  = 1'b0;
      cnt_d   = '0;
      base_d  = radix_q;
      if (radix_q == tip_pkg::RADIX_ONE || radix_q > tip_pkg::RADIX_MAX) begin
        base_err = 1'b1;
        phase_d  = PH_IDLE;
        done     = 1'b1;
      end
    end else if (phase_q == PH_IDLE) begin
      done = 1'b1;
    end

    if (!done && phase_d == PH_SPACE) begin
      if (tok_i.is_space) begin
        cnt_d = bump(cnt_d);
        done  = 1'b1;
      end else begin
        phase_d = PH_SIGNED;
        if (tok_i.is_sign) begin
          neg_d = tok_i.is_minus;
          cnt_d = bump(cnt_d);
          done  = 1'b1;
        end
      end
    end

    if (!done && phase_d == PH_SIGNED) begin
      if (tok_i.is_zero) begin
        cnt_d   = bump(cnt_d);
        seen_d  = 1'b1;
        phase_d = (base_d == tip_pkg::RADIX_AUTO || base_d == tip_pkg::BASE_HEX) ?
                  PH_ZERO : PH_DIGITS;
      end else begin
        if (base_d == tip_pkg::RADIX_AUTO) begin
          base_d = tip_pkg::BASE_DEC;
        end
        try_take = 1'b1;
      end
      done = 1'b1;
    end

    if (!done && phase_d == PH_ZERO) begin
      if (tok_i.is_x) begin
        phase_d = PH_ZEROX;
        done    = 1'b1;
      end else begin
        if (base_d == tip_pkg::RADIX_AUTO) begin
          base_d = tip_pkg::BASE_OCT;
        end
        phase_d = PH_DIGITS;
      end
    end

    if (!done && phase_d == PH_ZEROX) begin
      base_d = tip_pkg::BASE_HEX;
      if (tok_i.digit < tip_pkg::HEX_LIMIT) begin
        // the x of the prefix counts once a hex digit follows
        cnt_d    = bump(cnt_d);
        try_take = 1'b1;
      end else begin
        fin = 1'b1;
      end
      done = 1'b1;
    end

    if (!done && phase_d == PH_DIGITS) begin
      try_take = 1'b1;
    end

    if (try_take) begin
      take_ok = (base_d >= tip_pkg::BASE_MIN) && (tok_i.digit < base_d);
      if (take_ok) begin
        prod = PROD_W'(acc_d) * PROD_W'(base_d) + PROD_W'(tok_i.digit);
        if (!ovf_d) begin
          if (|prod[PROD_W-1:VALUE_WIDTH]) begin
            ovf_d = 1'b1;
            acc_d = '1;
          end else begin
            acc_d = prod[VALUE_WIDTH-1:0];
          end
        end
        cnt_d   = bump(cnt_d);
        seen_d  = 1'b1;
        phase_d = PH_DIGITS;
      end else begin
        fin = 1'b1;
      end
    end

    if (fin) begin
      phase_d = PH_IDLE;
    end
  end

  // saturation and sign, from the state as the number ends
  always_comb begin
    fin_err   = tip_pkg::ERR_OK;
    fin_value = neg_d ? (~acc_d + 1'b1) : acc_d;
    if (ovf_d) begin
      fin_err = tip_pkg::ERR_RANGE;
      if (!signed_q) begin
        fin_value = '1;
      end else begin
        fin_value = neg_d ? SMIN : SMAX;
      end
    end else if (signed_q && neg_d && acc_d[VALUE_WIDTH-1] &&
                 (|acc_d[VALUE_WIDTH-2:0])) begin
      fin_err   = tip_pkg::ERR_RANGE;
      fin_value = SMIN;
    end else if (signed_q && !neg_d && acc_d[VALUE_WIDTH-1]) begin
      fin_err   = tip_pkg::ERR_RANGE;
      fin_value = SMAX;
    end
  end

  assign emit = pop && (fin || base_err);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      acc_q   <= '0;
      neg_q   <= 1'b0;
      ovf_q   <= 1'b0;
      seen_q  <= 1'b0;
      base_q  <= tip_pkg::BASE_DEC;
      cnt_q   <= '0;
    end else if (pop) begin
      phase_q <= phase_d;
      acc_q   <= acc_d;
      neg_q   <= neg_d;
      ovf_q   <= ovf_d;
      seen_q  <= seen_d;
      base_q  <= base_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (emit) begin
      res_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      if (base_err) begin
        res_value_q <= '0;
        res_cnt_q   <= '0;
        res_err_q   <= tip_pkg::ERR_BASE;
      end else begin
        res_value_q <= fin_value;
        res_cnt_q   <= seen_d ? cnt_d : '0;
        res_err_q   <= fin_err;
      end
    end
  end

  assign res_o.valid      = res_valid_q;
  assign res_o.value_bits = res_value_q;
  assign res_o.chars_used = res_cnt_q;
  assign res_o.error_code = res_err_q;

endmodule

`default_nettype wire

// ----- test/tip_checker.sv -----
// checker for the text-to-integer parser: follows the characters and compares each result word
`timescale 1ns / 1ps

module tip_checker
  import tip_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  tip_in_if                     str_i,
  tip_out_if                    res_i,
  output int                    fail_cnt_o,
  output int                    pending_o
);

  localparam int unsigned VALUE_W = DEF_VALUE_WIDTH;
  localparam int unsigned CNT_W   = $clog2(DEF_MAX_LEN + 1);

  localparam logic [VALUE_W-1:0] ALL_ONES = '1;
  localparam logic [VALUE_W-1:0] POS_MAX  = ALL_ONES >> 1;
  localparam logic [VALUE_W-1:0] NEG_MAX  = ~POS_MAX;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_BLANKS,
    ST_NUMBER_START,
    ST_LEAD_ZERO,
    ST_HEX_MARK,
    ST_DIGITS
  } scan_state_e;

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic [CNT_W-1:0]   used;
    err_e               err;
  } outcome_t;

  logic [RADIX_W-1:0] radix_q  = RADIX_RESET;
  logic               signed_q = 1'b1;
  scan_state_e        state_q  = ST_IDLE;
  logic [VALUE_W-1:0] acc_q    = '0;
  logic               neg_q    = 1'b0;
  logic               ovf_q    = 1'b0;
  logic [RADIX_W-1:0] base_q   = BASE_DEC;
  logic [CNT_W-1:0]   used_q   = '0;
  logic [CNT_W-1:0]   digits_q = '0;
  outcome_t           parsed_q[$];
  int                 fails    = 0;

  function automatic int unsigned char_weight(input logic [CHAR_W-1:0] c);
    if (c >= CH_0 && c <= CH_9) return c - CH_0;
    if (c >= CH_UA && c <= CH_UZ) return c - CH_UA + BASE_DEC;
    if (c >= CH_LA && c <= CH_LZ) return c - CH_LA + BASE_DEC;
    return NO_DIGIT;
  endfunction

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] n);
    return (n < CNT_W'(DEF_MAX_LEN)) ? n + 1'b1 : n;
  endfunction

  // multiply-add one digit, stick at all ones once the value no longer fits
  function automatic bit absorb_digit(input logic [CHAR_W-1:0] c);
    int unsigned d;
    d = char_weight(c);
    if (base_q < BASE_MIN || d >= base_q) return 1'b0;
    if (!ovf_q) begin
      if (64'(acc_q) > (64'(ALL_ONES) - d) / base_q) begin
        ovf_q = 1'b1;
        acc_q = ALL_ONES;
      end else begin
        acc_q = acc_q * base_q + d;
      end
    end
    used_q   = sat_inc(used_q);
    digits_q = sat_inc(digits_q);
    return 1'b1;
  endfunction

  function automatic outcome_t wrap_up();
    outcome_t r;
    r.err = ERR_OK;
    if (ovf_q) begin
      r.err   = ERR_RANGE;
      r.value = !signed_q ? ALL_ONES : (neg_q ? NEG_MAX : POS_MAX);
    end else if (signed_q && neg_q && acc_q > NEG_MAX) begin
      r.err   = ERR_RANGE;
      r.value = NEG_MAX;
    end else if (signed_q && !neg_q && acc_q > POS_MAX) begin
      r.err   = ERR_RANGE;
      r.value = POS_MAX;
    end else begin
      r.value = neg_q ? -acc_q : acc_q;
    end
    r.used  = (digits_q != 0) ? used_q : '0;
    state_q = ST_IDLE;
    return r;
  endfunction

  // returns 1 when this character produces a result word
  function automatic bit scan_char(input logic [CHAR_W-1:0] c, input logic first,
                                   output outcome_t r);
    r = '0;
    if (first) begin
      acc_q    = '0;
      neg_q    = 1'b0;
      ovf_q    = 1'b0;
      used_q   = '0;
      digits_q = '0;
      base_q   = radix_q;
      if (radix_q == RADIX_ONE || radix_q > RADIX_MAX) begin
        r.err   = ERR_BASE;
        state_q = ST_IDLE;
        return 1'b1;
      end
      state_q = ST_BLANKS;
    end else if (state_q == ST_IDLE) begin
      return 1'b0;
    end

    if (state_q == ST_BLANKS) begin
      if (c == CH_SPACE || (c >= CH_TAB && c <= CH_CR)) begin
        used_q = sat_inc(used_q);
        return 1'b0;
      end
      state_q = ST_NUMBER_START;
      if (c == CH_MINUS || c == CH_PLUS) begin
        neg_q  = (c == CH_MINUS);
        used_q = sat_inc(used_q);
        return 1'b0;
      end
    end
    if (state_q == ST_NUMBER_START) begin
      if (c == CH_0) begin
        used_q   = sat_inc(used_q);
        digits_q = sat_inc(digits_q);
        state_q  = (base_q == RADIX_AUTO || base_q == BASE_HEX) ? ST_LEAD_ZERO : ST_DIGITS;
        return 1'b0;
      end
      if (base_q == RADIX_AUTO) base_q = BASE_DEC;
      if (absorb_digit(c)) begin
        state_q = ST_DIGITS;
        return 1'b0;
      end
      r = wrap_up();
      return 1'b1;
    end
    if (state_q == ST_LEAD_ZERO) begin
      if (c == CH_LX || c == CH_UX) begin
        state_q = ST_HEX_MARK;
        return 1'b0;
      end
      if (base_q == RADIX_AUTO) base_q = BASE_OCT;
      state_q = ST_DIGITS;
    end
    if (state_q == ST_HEX_MARK) begin
      base_q = BASE_HEX;
      // the x only counts once a hex digit follows it
      if (char_weight(c) < HEX_LIMIT) begin
        used_q = sat_inc(used_q);
        void'(absorb_digit(c));
        state_q = ST_DIGITS;
        return 1'b0;
      end
      r = wrap_up();
      return 1'b1;
    end
    if (state_q == ST_DIGITS) begin
      if (absorb_digit(c)) return 1'b0;
      r = wrap_up();
      return 1'b1;
    end
    state_q = ST_IDLE;
    return 1'b0;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    outcome_t got;
    outcome_t want;
    outcome_t fresh;
    if (!rst_ni) begin
      radix_q  = RADIX_RESET;
      signed_q = 1'b1;
      state_q  = ST_IDLE;
      acc_q    = '0;
      neg_q    = 1'b0;
      ovf_q    = 1'b0;
      base_q   = BASE_DEC;
      used_q   = '0;
      digits_q = '0;
      parsed_q.delete();
    end else begin
      if (res_i.valid && res_i.ready) begin
        got.value = res_i.value_bits;
        got.used  = res_i.chars_used;
        got.err   = err_e'(res_i.error_code);
        if (parsed_q.size() == 0) begin
          $display("%0t: result word with nothing pending: expected none, actual %h/%0d/%0d",
                   $time, got.value, got.used, got.err);
          fails++;
        end else begin
          want = parsed_q.pop_front();
          if (got.value !== want.value) begin
            $display("%0t: value_bits expected %h actual %h", $time, want.value, got.value);
            fails++;
          end
          if (got.used !== want.used) begin
            $display("%0t: chars_used expected %0d actual %0d", $time, want.used, got.used);
            fails++;
          end
          if (got.err !== want.err) begin
            $display("%0t: error_code expected %0d actual %0d", $time, want.err, got.err);
            fails++;
          end
        end
      end
      if (str_i.valid && str_i.ready) begin
        if (scan_char(str_i.char_code, str_i.first_char, fresh)) parsed_q.push_back(fresh);
      end
      if (cfg_we_i) begin
        if (cfg_idx_e'(cfg_idx_i) == CFG_RADIX) radix_q = cfg_data_i[RADIX_W-1:0];
        else signed_q = cfg_data_i[0];
      end
    end
    fail_cnt_o <= fails;
    pending_o  <= parsed_q.size();
  end

endmodule

// ----- test/tb_top.sv -----
// testbench top for the text-to-integer parser: clock, reset, character stimulus, stalls, verdict
`timescale 1ns / 1ps

module tb_top;
  import tip_pkg::*;

  localparam int unsigned HALF_PERIOD   = 5;
  localparam int unsigned MAX_WAIT      = 16;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned QUIET_LIMIT   = 2000;
  localparam int unsigned PHASE_ITEMS   = 20;
  localparam int unsigned RAND_PHASES   = 12;
  localparam int unsigned LONG_BLANKS   = 500;
  localparam int unsigned LONG_ZEROS    = 530;

  localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
  localparam logic [CHAR_W-1:0] CH_DOT   = 8'h2e;
  localparam logic [CHAR_W-1:0] CH_PUNCT = 8'h21;  // '!' .. '/' hold no digit
  localparam logic [CHAR_W-1:0] CH_SLASH = 8'h2f;

  localparam logic [63:0] POS_LIMIT = 64'h7fff_ffff;
  localparam logic [63:0] WRAP      = 64'h1_0000_0000;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  take_res = 1'b0;
  int                    fail_cnt;
  int                    pending;
  int unsigned           quiet_cycles = 0;
  int unsigned           hold_left    = 0;
  int unsigned           items_sent   = 0;
  bit                    src_calm     = 1'b0;
  bit                    sink_calm    = 1'b0;
  logic [CHAR_W-1:0]     text_q[$];

  tip_in_if  str_if ();
  tip_out_if res_if ();

  assign res_if.ready = take_res;

  text_to_integer_parser i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .str_i      (str_if),
    .res_o      (res_if)
  );

  tip_checker i_checker (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .str_i      (str_if),
    .res_i      (res_if),
    .fail_cnt_o (fail_cnt),
    .pending_o  (pending)
  );

  always #HALF_PERIOD clk_i = ~clk_i;

  // result side: random hold-off before each word, with calm stretches
  always @(posedge clk_i or negedge rst_ni) begin : sink
    int unsigned n;
    if (!rst_ni) begin
      take_res  <= 1'b0;
      hold_left <= 0;
    end else if (take_res && res_if.valid) begin
      n = sink_calm ? 0 : $urandom_range(MAX_WAIT, 0);
      if ($urandom_range(7, 0) == 0) sink_calm <= !sink_calm;
      if (n == 0) begin
        take_res <= 1'b1;
      end else begin
        take_res  <= 1'b0;
        hold_left <= n - 1;
      end
    end else if (!take_res) begin
      if (hold_left == 0) take_res <= 1'b1;
      else hold_left <= hold_left - 1;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((str_if.valid && str_if.ready) || (res_if.valid && res_if.ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  task automatic send_char(input logic [CHAR_W-1:0] c, input logic first);
    int unsigned gap;
    gap = src_calm ? 0 : $urandom_range(MAX_WAIT, 0);
    if (gap != 0) begin
      str_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    str_if.valid      <= 1'b1;
    str_if.char_code  <= c;
    str_if.first_char <= first;
    @(posedge clk_i);
    while (!str_if.ready) @(posedge clk_i);
    items_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i], i == 0);
  endtask

  task automatic send_queued();
    if ($urandom_range(15, 0) == 0) src_calm = !src_calm;
    foreach (text_q[i]) send_char(text_q[i], i == 0);
  endtask

  // wait for every pending word, then let the pipeline drain before touching registers
  task automatic settle();
    str_if.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_config(input logic [RADIX_W-1:0] rdx, input logic sgn);
    cfg_we   <= 1'b1;
    cfg_idx  <= CFG_RADIX;
    cfg_data <= rdx;
    @(posedge clk_i);
    cfg_idx  <= CFG_SIGNED;
    cfg_data <= CFG_DATA_W'(sgn);
    @(posedge clk_i);
    cfg_we   <= 1'b0;
  endtask

  function automatic logic [CHAR_W-1:0] digit_char(input int unsigned d);
    if (d < BASE_DEC) return CHAR_W'(CH_0 + d);
    return CHAR_W'(($urandom_range(1, 0) ? CH_LA : CH_UA) + d - BASE_DEC);
  endfunction

  task automatic push_value(input logic [63:0] v, input int unsigned eb);
    logic [CHAR_W-1:0] tmp[$];
    do begin
      tmp.push_front(digit_char(32'(v % eb)));
      v = v / eb;
    end while (v != 0);
    foreach (tmp[i]) text_q.push_back(tmp[i]);
  endtask

  // one number: blanks, sign, prefix, digits and an ending, all optional
  task automatic build_number(input logic [RADIX_W-1:0] rdx);
    int unsigned eb;
    int unsigned n;
    logic [63:0] v;
    text_q.delete();
    eb = (rdx >= BASE_MIN && rdx <= RADIX_MAX) ? rdx : BASE_DEC;
    if ($urandom_range(3, 0) == 0) begin
      n = $urandom_range(3, 1);
      repeat (n) text_q.push_back($urandom_range(1, 0) ? CH_SPACE
                                                       : CHAR_W'($urandom_range(CH_CR, CH_TAB)));
    end
    case ($urandom_range(2, 0))
      1: text_q.push_back(CH_PLUS);
      2: text_q.push_back(CH_MINUS);
      default: ;
    endcase
    if (rdx == RADIX_AUTO) begin
      case ($urandom_range(2, 0))
        0: begin
          text_q.push_back(CH_0);
          text_q.push_back($urandom_range(1, 0) ? CH_LX : CH_UX);
          eb = BASE_HEX;
        end
        1: begin
          text_q.push_back(CH_0);
          eb = BASE_OCT;
        end
        default: eb = BASE_DEC;
      endcase
    end else if (rdx == BASE_HEX && $urandom_range(1, 0)) begin
      text_q.push_back(CH_0);
      text_q.push_back($urandom_range(1, 0) ? CH_LX : CH_UX);
    end
    case ($urandom_range(7, 0))
      0: ;
      1: begin
        n = $urandom_range(40, 20);
        repeat (n) text_q.push_back(digit_char($urandom_range(eb - 1, 0)));
      end
      2: begin
        case ($urandom_range(5, 0))
          0: v = POS_LIMIT;
          1: v = POS_LIMIT + 1;
          2: v = POS_LIMIT + 2;
          3: v = WRAP - 1;
          4: v = WRAP;
          default: v = 64'($urandom);
        endcase
        push_value(v, eb);
      end
      default: begin
        n = $urandom_range(8, 1);
        repeat (n) text_q.push_back(digit_char($urandom_range(eb - 1, 0)));
      end
    endcase
    case ($urandom_range(4, 0))
      0: text_q.push_back(CH_NUL);
      1: text_q.push_back(CHAR_W'($urandom_range(CH_SLASH, CH_PUNCT)));
      2: text_q.push_back(CHAR_W'($urandom));
      3: text_q.push_back(eb < RADIX_MAX ? digit_char($urandom_range(RADIX_MAX - 1, eb)) : CH_NUL);
      default: ;  // left open; a later character ends it or the next first char drops it
    endcase
  endtask

  task automatic run_phase(input logic [RADIX_W-1:0] rdx);
    int unsigned stop_at;
    int unsigned n;
    stop_at = items_sent + PHASE_ITEMS;
    while (items_sent < stop_at) begin
      if ($urandom_range(9, 0) == 0) begin
        n = $urandom_range(4, 1);
        repeat (n) send_char(CHAR_W'($urandom), $urandom_range(3, 0) == 0);
      end else begin
        build_number(rdx);
        send_queued();
      end
    end
    send_char(CH_NUL, 1'b0);
  endtask

  initial begin : stimulus
    logic [RADIX_W-1:0] rdx;
    logic               sgn;
    rst_ni              = 1'b0;
    cfg_we              = 1'b0;
    cfg_idx             = CFG_RADIX;
    cfg_data            = '0;
    str_if.valid        = 1'b0;
    str_if.char_code    = '0;
    str_if.first_char   = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed words, starting at the reset settings
    send_char('1, 1'b0);       // no conversion open: ignored
    send_text("5");            // dropped by the restart below
    send_text("\t-7");
    send_char(CH_NUL, 1'b0);
    send_text("+Z");           // letter beyond base 10, no digits
    settle();
    set_config(RADIX_AUTO, 1'b1);
    send_text("0xg");          // bare hex prefix
    send_text("078");          // octal, 8 ends it
    settle();
    set_config(RADIX_ONE, 1'b1);
    send_text("1");
    settle();
    set_config('1, 1'b0);
    send_text("9");
    settle();
    set_config(BASE_HEX, 1'b0);
    send_text("-0X1f~");       // unsigned negative wraps

    // count saturation on one very long number
    settle();
    set_config(BASE_DEC, 1'b1);
    text_q.delete();
    repeat (LONG_BLANKS) text_q.push_back($urandom_range(1, 0) ? CH_SPACE : CH_TAB);
    text_q.push_back(CH_PLUS);
    repeat (LONG_ZEROS) text_q.push_back(CH_0);
    text_q.push_back(digit_char(4));
    text_q.push_back(digit_char(2));
    text_q.push_back(CH_DOT);
    send_queued();

    for (int p = 0; p < RAND_PHASES; p++) begin
      case (p)
        0: rdx = BASE_MIN;
        1: rdx = RADIX_MAX;
        2: rdx = RADIX_AUTO;
        3: rdx = '1;
        default: begin
          case ($urandom_range(9, 0))
            0, 1, 2: rdx = RADIX_AUTO;
            3: rdx = BASE_HEX;
            4: rdx = BASE_DEC;
            5: rdx = BASE_OCT;
            6: rdx = RADIX_ONE;
            7: rdx = RADIX_W'($urandom_range(63, RADIX_MAX + 1));
            default: rdx = RADIX_W'($urandom_range(RADIX_MAX, BASE_MIN));
          endcase
        end
      endcase
      sgn = (p < 4) ? 1'(p % 2) : 1'($urandom_range(1, 0));
      settle();
      set_config(rdx, sgn);
      run_phase(rdx);
    end

    settle();
    if (fail_cnt == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/tip_pkg.sv
rtl/tip_in_if.sv
rtl/tip_out_if.sv
rtl/tip_front.sv
rtl/tip_queue.sv
rtl/tip_back.sv
rtl/text_to_integer_parser.sv
test/tip_checker.sv
test/tb_top.sv
